FILE: src/three_nearest_selector_defines.svh
// ============================================================================
// Three-nearest selector assertion macros
// Shared property wrappers for the port checker of the selector.
// ============================================================================
`ifndef THREE_NEAREST_SELECTOR_DEFINES_SVH
`define THREE_NEAREST_SELECTOR_DEFINES_SVH

// Property sampled on the rising clock edge, switched off while reset is low
`define TNS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
    else $error(msg);

// Property sampled on the rising clock edge, also checked during reset
`define TNS_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

FILE: src/tns_pkg.sv
// ============================================================================
// tns_pkg
// Widths, stream field offsets and slot types of the three-nearest selector.
// ============================================================================
`default_nettype none

package tns_pkg;

    // Number of kept candidates and value width
    localparam int NUM_NEAREST = 3;
    localparam int VALUE_WIDTH = 32;
    localparam int DIST_W      = VALUE_WIDTH - 1;
    localparam int INDEX_W     = 16;
    localparam int OUT_INDEX_W = 17;
    localparam int RANK_W      = 2;

    // Cutoff after reset: 1001.0 in Q15.16
    localparam logic [DIST_W-1:0] CUTOFF_RESET = DIST_W'(65601536);
    localparam logic [RANK_W-1:0] LAST_RANK    = RANK_W'(NUM_NEAREST - 1);

    // Slave tdata: distance, x, y, charge, hit index (low to high)
    localparam int IN_DIST_LSB  = 0;
    localparam int IN_X_LSB     = IN_DIST_LSB + VALUE_WIDTH;
    localparam int IN_Y_LSB     = IN_X_LSB + VALUE_WIDTH;
    localparam int IN_Q_LSB     = IN_Y_LSB + VALUE_WIDTH;
    localparam int IN_IDX_LSB   = IN_Q_LSB + VALUE_WIDTH;
    localparam int IN_USED_W    = IN_IDX_LSB + INDEX_W;
    localparam int IN_TDATA_W   = ((IN_USED_W + 7) / 8) * 8;

    // Master tdata: x, y, charge, index (low to high)
    localparam int OUT_X_LSB    = 0;
    localparam int OUT_Y_LSB    = OUT_X_LSB + VALUE_WIDTH;
    localparam int OUT_Q_LSB    = OUT_Y_LSB + VALUE_WIDTH;
    localparam int OUT_IDX_LSB  = OUT_Q_LSB + VALUE_WIDTH;
    localparam int OUT_USED_W   = OUT_IDX_LSB + OUT_INDEX_W;
    localparam int OUT_TDATA_W  = ((OUT_USED_W + 7) / 8) * 8;

    // Master tuser: rank, found (low to high)
    localparam int OUT_FOUND_BIT = RANK_W;
    localparam int OUT_TUSER_W   = RANK_W + 1;

    // One kept candidate
    typedef struct packed {
        logic                   used;
        logic [DIST_W-1:0]      abs_dist;
        logic [VALUE_WIDTH-1:0] x;
        logic [VALUE_WIDTH-1:0] y;
        logic [VALUE_WIDTH-1:0] q;
        logic [INDEX_W-1:0]     idx;
    } t_slot;

    // One result waiting for transfer
    typedef struct packed {
        logic                   found;
        logic [VALUE_WIDTH-1:0] x;
        logic [VALUE_WIDTH-1:0] y;
        logic [VALUE_WIDTH-1:0] q;
        logic [OUT_INDEX_W-1:0] idx;
    } t_result;

endpackage

`default_nettype wire

FILE: src/three_nearest_selector.sv
// ============================================================================
// three_nearest_selector
// Keeps the three candidates of a set with the smallest absolute distance
// and sends them out in ascending order when the set closes.
// ============================================================================
//
//  channel   | direction | contents
//  ----------+-----------+-------------------------------------------------
//  cfg       | in        | distance cutoff, write enable only
//  s_axis    | in        | one candidate per transfer, tlast closes the set
//  m_axis    | out       | three ranked results per set, tlast on rank 2
//
//  One candidate is accepted every cycle unless a closing item waits. It
//  enters the input register (absolute distance already formed), and three
//  slot comparators insert it. On the closing item the sorted slots move to
//  a result bank and the slots clear, so the next set starts at once; the
//  bank drains one result per cycle while m_axis_tready is high. A closing
//  item waits in the input register only while the previous set's results
//  are still in the bank. Reset is synchronous, active low, and sets the
//  cutoff to 1001.0.
`default_nettype none

module three_nearest_selector (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration
    input  logic                            i_cfg_wr_en,
    input  logic [tns_pkg::DIST_W-1:0]      i_cfg_wr_data,
    // candidate stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // distance, x_coord, y_coord, charge, hit_index
    input  logic [tns_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic                            s_axis_tlast,
    // entry_valid
    input  logic                            s_axis_tuser,
    // result stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // out_x, out_y, out_charge, out_index
    output logic [tns_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                            m_axis_tlast,
    // rank, found
    output logic [tns_pkg::OUT_TUSER_W-1:0] m_axis_tuser
);

    localparam int VW = tns_pkg::VALUE_WIDTH;
    localparam int DW = tns_pkg::DIST_W;
    localparam int NN = tns_pkg::NUM_NEAREST;

    // configuration register
    logic [DW-1:0] r_cutoff;

    // input register
    logic                        r_in_valid;
    logic                        r_in_entry;
    logic                        r_in_last;
    logic [DW-1:0]               r_in_abs;
    logic [VW-1:0]               r_in_x;
    logic [VW-1:0]               r_in_y;
    logic [VW-1:0]               r_in_q;
    logic [tns_pkg::INDEX_W-1:0] r_in_idx;

    // slots and result bank
    tns_pkg::t_slot   r_slot [NN];
    tns_pkg::t_result r_bank [NN];
    logic                       r_bank_active;
    logic [tns_pkg::RANK_W-1:0] r_ptr;

    logic [VW-1:0]    in_dist;
    logic [DW-1:0]    in_neg;
    logic [DW-1:0]    n_in_abs;
    logic             ins;
    logic             keep [NN];
    tns_pkg::t_slot   cand;
    tns_pkg::t_slot   n_slot [NN];
    tns_pkg::t_result n_res  [NN];
    logic             bank_free;
    logic             adv;

    // saturating absolute distance of the incoming candidate
    assign in_dist = s_axis_tdata[tns_pkg::IN_DIST_LSB +: VW];
    assign in_neg  = ~in_dist[DW-1:0] + DW'(1);

    always_comb begin
        if (!in_dist[VW-1]) begin
            n_in_abs = in_dist[DW-1:0];
        end else if (in_dist == {1'b1, {DW{1'b0}}}) begin
            n_in_abs = {DW{1'b1}};
        end else begin
            n_in_abs = in_neg;
        end
    end

    // handshake: a closing item waits until the bank can take the set
    assign bank_free     = !r_bank_active || (m_axis_tready && (r_ptr == tns_pkg::LAST_RANK));
    assign adv           = r_in_valid && (!r_in_last || bank_free);
    assign s_axis_tready = !r_in_valid || adv;

    // candidate entry for the slots
    assign ins = r_in_entry && (r_in_abs < r_cutoff);

    always_comb begin
        cand.used     = 1'b1;
        cand.abs_dist = r_in_abs;
        cand.x        = r_in_x;
        cand.y        = r_in_y;
        cand.q        = r_in_q;
        cand.idx      = r_in_idx;
    end

    // sorted insert: slots at or below the new distance stay, the first
    // other slot takes the candidate, the rest shift down by one
    for (genvar g = 0; g < NN; g++) begin : g_slot
        assign keep[g] = r_slot[g].used && (r_slot[g].abs_dist <= r_in_abs);

        if (g == 0) begin : g_first
            always_comb begin
                if (!ins || keep[g]) begin
                    n_slot[g] = r_slot[g];
                end else begin
                    n_slot[g] = cand;
                end
            end
        end else begin : g_rest
            always_comb begin
                if (!ins || keep[g]) begin
                    n_slot[g] = r_slot[g];
                end else if (keep[g-1]) begin
                    n_slot[g] = cand;
                end else begin
                    n_slot[g] = r_slot[g-1];
                end
            end
        end

        // empty slots give the cutoff and an index of all ones
        always_comb begin
            n_res[g].found = n_slot[g].used;
            if (n_slot[g].used) begin
                n_res[g].x   = n_slot[g].x;
                n_res[g].y   = n_slot[g].y;
                n_res[g].q   = n_slot[g].q;
                n_res[g].idx = {1'b0, n_slot[g].idx};
            end else begin
                n_res[g].x   = {{(VW-DW){1'b0}}, r_cutoff};
                n_res[g].y   = {{(VW-DW){1'b0}}, r_cutoff};
                n_res[g].q   = {{(VW-DW){1'b0}}, r_cutoff};
                n_res[g].idx = {tns_pkg::OUT_INDEX_W{1'b1}};
            end
        end
    end

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cutoff <= tns_pkg::CUTOFF_RESET;
        end else if (i_cfg_wr_en) begin
            r_cutoff <= i_cfg_wr_data;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_entry <= s_axis_tuser;
            r_in_last  <= s_axis_tlast;
            r_in_abs   <= n_in_abs;
            r_in_x     <= s_axis_tdata[tns_pkg::IN_X_LSB +: VW];
            r_in_y     <= s_axis_tdata[tns_pkg::IN_Y_LSB +: VW];
            r_in_q     <= s_axis_tdata[tns_pkg::IN_Q_LSB +: VW];
            r_in_idx   <= s_axis_tdata[tns_pkg::IN_IDX_LSB +: tns_pkg::INDEX_W];
        end
    end

    // slots: insert, and clear after a closing item
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NN; i++) begin
            if (!i_rst_n) begin
                r_slot[i].used <= 1'b0;
            end else if (adv) begin
                if (r_in_last) begin
                    r_slot[i].used <= 1'b0;
                end else begin
                    r_slot[i] <= n_slot[i];
                end
            end
        end
    end

    // result bank: load on a closing item, drain one result per transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank_active <= 1'b0;
            r_ptr         <= '0;
        end else if (adv && r_in_last) begin
            r_bank_active <= 1'b1;
            r_ptr         <= '0;
        end else if (r_bank_active && m_axis_tready) begin
            if (r_ptr == tns_pkg::LAST_RANK) begin
                r_bank_active <= 1'b0;
            end else begin
                r_ptr <= r_ptr + tns_pkg::RANK_W'(1);
            end
        end
        if (adv && r_in_last) begin
            for (int i = 0; i < NN; i++) begin
                r_bank[i] <= n_res[i];
            end
        end
    end

    // result stream
    assign m_axis_tvalid = r_bank_active;
    assign m_axis_tlast  = (r_ptr == tns_pkg::LAST_RANK);
    assign m_axis_tuser  = {r_bank[r_ptr].found, r_ptr};

    always_comb begin
        m_axis_tdata = '0;
        m_axis_tdata[tns_pkg::OUT_X_LSB +: VW] = r_bank[r_ptr].x;
        m_axis_tdata[tns_pkg::OUT_Y_LSB +: VW] = r_bank[r_ptr].y;
        m_axis_tdata[tns_pkg::OUT_Q_LSB +: VW] = r_bank[r_ptr].q;
        m_axis_tdata[tns_pkg::OUT_IDX_LSB +: tns_pkg::OUT_INDEX_W] = r_bank[r_ptr].idx;
    end

endmodule

`default_nettype wire

FILE: src/tns_checker.sv
// ============================================================================
// tns_checker
// Port checks on the result stream of the three-nearest selector.
// ============================================================================
`default_nettype none

`include "three_nearest_selector_defines.svh"

module tns_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    input  logic [tns_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                            m_axis_tlast,
    input  logic [tns_pkg::OUT_TUSER_W-1:0] m_axis_tuser
);

    // no result leaves the block right after reset
    `TNS_ASSERT_RST(a_idle_after_reset, !i_rst_n |=> !m_axis_tvalid, "result valid after reset")

    // a stalled result holds
    `TNS_ASSERT(a_hold_on_stall, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "stalled result changed")

    // tlast marks the highest rank only
    `TNS_ASSERT(a_last_on_top_rank, m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser[tns_pkg::RANK_W-1:0] == tns_pkg::LAST_RANK)), "tlast and rank disagree")

    // an empty slot carries an index of all ones
    `TNS_ASSERT(a_empty_index, m_axis_tvalid && !m_axis_tuser[tns_pkg::OUT_FOUND_BIT] |-> (m_axis_tdata[tns_pkg::OUT_IDX_LSB +: tns_pkg::OUT_INDEX_W] == {tns_pkg::OUT_INDEX_W{1'b1}}), "empty slot with index")

    // ranks of one set follow each other without a gap
    `TNS_ASSERT(a_rank_step, m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid && (m_axis_tuser[tns_pkg::RANK_W-1:0] == $past(m_axis_tuser[tns_pkg::RANK_W-1:0]) + tns_pkg::RANK_W'(1)), "rank skipped")

endmodule

bind three_nearest_selector tns_checker u_tns_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
